>>> rtl/lts_pkg.sv
// Shared types and constants for the LIS tail-table search block.
package lts_pkg;

  // Default tail-table depth
  localparam int MAX_LEN_DEF = 1024;

  // Fixed field widths of the stream beats
  localparam int VALUE_W   = 32;
  localparam int LEN_OUT_W = 11;
  localparam int SLOT_W    = 10;
  localparam int S_DATA_W  = 32;
  localparam int M_DATA_W  = 24;
  localparam int M_USER_W  = 2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // One result beat as produced by the search controller
  typedef struct packed {
    logic [LEN_OUT_W-1:0] lis_length;
    logic [SLOT_W-1:0]    slot_written;
    logic                 appended;
    logic                 overflow;
  } result_t;

endpackage

>>> rtl/lts_mem.sv
// Tail table: single-port synchronous RAM with registered read.
module lts_mem #(
  parameter int MAX_LEN = lts_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_LEN)-1:0]   addr,
  input  lts_pkg::value_t              wr_data,
  output lts_pkg::value_t              rd_data
);
  import lts_pkg::*;

  value_t mem [MAX_LEN];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> rtl/lts_ctrl.sv
// Sequencer: length register, last-tail check and binary search over the tail RAM.
module lts_ctrl #(
  parameter int MAX_LEN = lts_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // item in
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lts_pkg::value_t              in_value,
  input  logic                         in_start_new,
  // result out
  output logic                         res_valid,
  input  logic                         res_ready,
  output lts_pkg::result_t             res,
  // tail RAM port
  output logic                         mem_wr_en,
  output logic                         mem_rd_en,
  output logic [$clog2(MAX_LEN)-1:0]   mem_addr,
  output lts_pkg::value_t              mem_wr_data,
  input  lts_pkg::value_t              mem_rd_data
);
  import lts_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    LAST = 4'b0010,
    SRCH = 4'b0100,
    DONE = 4'b1000
  } state_t;

  state_t          state, state_next;
  value_t          value;
  logic [LW-1:0]   len, len_next;
  logic [AW-1:0]   lo, lo_next;
  logic [AW-1:0]   hi, hi_next;
  logic [AW-1:0]   mid, mid_next;
  logic [AW-1:0]   slot, slot_next;
  logic            app, app_next;
  logic            ovf, ovf_next;

  logic            accept;
  logic [LW-1:0]   len_eff;
  logic [AW-1:0]   hi_init;
  logic [AW-1:0]   lo_step, hi_step;
  logic [AW:0]     mid_sum;

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == DONE);
  assign len_eff   = in_start_new ? '0 : len;
  assign hi_init   = AW'(len - LW'(1));

  // one search step on the tail just read
  always_comb begin
    if (mem_rd_data < value) begin
      lo_step = mid + AW'(1);
      hi_step = hi;
    end else begin
      lo_step = lo;
      hi_step = mid;
    end
  end

  assign mid_sum = ({1'b0, lo_step} + {1'b0, hi_step}) >> 1;

  // next state, RAM control and result capture
  always_comb begin
    state_next  = state;
    len_next    = len;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    slot_next   = slot;
    app_next    = app;
    ovf_next    = ovf;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_addr    = '0;
    mem_wr_data = value;

    unique case (state)
      IDLE: begin
        if (accept) begin
          slot_next = '0;
          app_next  = 1'b0;
          ovf_next  = 1'b0;
          if (len_eff == '0) begin
            // empty table: first tail goes straight to slot 0
            mem_wr_en   = 1'b1;
            mem_wr_data = in_value;
            len_next    = LW'(1);
            app_next    = 1'b1;
            state_next  = DONE;
          end else begin
            // fetch the last tail
            mem_rd_en  = 1'b1;
            mem_addr   = AW'(len_eff - LW'(1));
            len_next   = len_eff;
            state_next = LAST;
          end
        end
      end

      LAST: begin
        if (value > mem_rd_data) begin
          if (len < LW'(MAX_LEN)) begin
            mem_wr_en = 1'b1;
            mem_addr  = AW'(len);
            slot_next = AW'(len);
            len_next  = len + LW'(1);
            app_next  = 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          state_next = DONE;
        end else if (hi_init != '0) begin
          // start search over [0, len-1]
          lo_next    = '0;
          hi_next    = hi_init;
          mid_next   = hi_init >> 1;
          mem_rd_en  = 1'b1;
          mem_addr   = hi_init >> 1;
          state_next = SRCH;
        end else begin
          mem_wr_en  = 1'b1;
          state_next = DONE;
        end
      end

      SRCH: begin
        lo_next = lo_step;
        hi_next = hi_step;
        if (lo_step < hi_step) begin
          mid_next  = mid_sum[AW-1:0];
          mem_rd_en = 1'b1;
          mem_addr  = mid_sum[AW-1:0];
        end else begin
          // converged: replace first tail not below the value
          mem_wr_en  = 1'b1;
          mem_addr   = lo_step;
          slot_next  = lo_step;
          state_next = DONE;
        end
      end

      DONE: begin
        if (res_ready) begin
          state_next = IDLE;
        end
      end

      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      value <= in_value;
    end
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    slot <= slot_next;
    app  <= app_next;
    ovf  <= ovf_next;
  end

  // result beat, length and slot reported modulo their field widths
  assign res.lis_length   = LEN_OUT_W'(len);
  assign res.slot_written = SLOT_W'(slot);
  assign res.appended     = app;
  assign res.overflow     = ovf;

endmodule

>>> rtl/lis_tails_binary_search_unit.sv
// Top level: LIS tail table with binary-search replace and registered output beat.
// Flow: on an empty table or start_new the value goes straight to slot 0; an append, an
//   overflow or a replace at length 1 first reads the last tail; any other replace then
//   runs a binary search over the tail RAM before writing.
// Throughput: one item at a time; the next input beat is taken once the result enters the
//   output register, with one tail RAM read per search step. The output register lets the
//   next item start while a beat waits.
// Reset (rst, synchronous): length cleared, controller idle, output empty; tail RAM not cleared.
module lis_tails_binary_search_unit #(
  parameter int MAX_LEN = lts_pkg::MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [lts_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] value
  input  logic                      s_tuser,     // [0] start_new
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lts_pkg::M_DATA_W-1:0] m_tdata,  // [10:0] lis_length, [20:11] slot_written, zero pad
  output logic [lts_pkg::M_USER_W-1:0] m_tuser   // [0] appended, [1] overflow
);
  import lts_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  logic            mem_wr_en;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_addr;
  value_t          mem_wr_data;
  value_t          mem_rd_data;
  logic            res_valid;
  logic            res_ready;
  result_t         res;
  result_t         out_res;

  lts_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (mem_rd_en),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  lts_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_value     (value_t'(s_tdata)),
    .in_start_new (s_tuser),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_wr_en    (mem_wr_en),
    .mem_rd_en    (mem_rd_en),
    .mem_addr     (mem_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_data  (mem_rd_data)
  );

  // output beat register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = M_DATA_W'({out_res.slot_written, out_res.lis_length});
  assign m_tuser = {out_res.overflow, out_res.appended};

endmodule

>>> dv/lis_tails_binary_search_unit_tb.sv
// Testbench for the LIS tail-table search unit: directed table, random runs, table fill.
`timescale 1ns / 100ps

module lis_tails_binary_search_unit_tb;
  import lts_pkg::*;

  localparam int TB_MAX_LEN  = MAX_LEN_DEF;
  localparam int ITEM_TARGET = 1650;
  localparam int QUIET_AT    = ITEM_TARGET - 150;
  localparam int WDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 60;
  localparam int DIR_N       = 20;

  localparam value_t V_MAX = 32'sh7FFF_FFFF;
  localparam value_t V_MIN = 32'sh8000_0000;

  // Random run shapes
  typedef enum logic [2:0] {
    SEQ_SCATTER,
    SEQ_NARROW,
    SEQ_RISING,
    SEQ_FALLING,
    SEQ_NOISE
  } burst_kind_t;

  // One directed row; gold holds a hand-written result when has_gold is set
  typedef struct {
    value_t  v;
    bit      sn;
    bit      has_gold;
    result_t gold;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  // Predictor state: shadow tail table and current run length
  value_t  tail_tab [TB_MAX_LEN];
  int      run_len = 0;
  result_t lis_expect_q [$];

  int       err_cnt   = 0;
  int       items_in  = 0;
  int       gap_pct   = 0;
  bit       quiet     = 1'b0;
  int       idle_cyc  = 0;
  dir_row_t dir_rows [DIR_N];

  always #5 clk = ~clk;

  lis_tails_binary_search_unit #(
    .MAX_LEN(TB_MAX_LEN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [31:0] value
    .s_tuser (s_tuser),   // [0] start_new
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // [10:0] lis_length, [20:11] slot_written
    .m_tuser (m_tuser)    // [0] appended, [1] overflow
  );

  // Patience step: append above the last tail, else replace first tail not below v
  function automatic result_t predict_lis(input value_t v, input bit sn);
    result_t r;
    int lo, hi, mid;
    r = '0;
    if (sn) run_len = 0;
    if (run_len == 0) begin
      tail_tab[0] = v;
      run_len = 1;
      r.appended = 1'b1;
    end else if (v > tail_tab[run_len-1]) begin
      if (run_len < TB_MAX_LEN) begin
        tail_tab[run_len] = v;
        r.slot_written = SLOT_W'(run_len);
        run_len++;
        r.appended = 1'b1;
      end else begin
        r.overflow = 1'b1;
      end
    end else begin
      lo = 0;
      hi = run_len - 1;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (tail_tab[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      tail_tab[lo] = v;
      r.slot_written = SLOT_W'(lo);
    end
    r.lis_length = LEN_OUT_W'(run_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Offer one beat, with an optional idle burst first; logs the expectation on accept
  task automatic send_item(input value_t v, input bit sn, input bit has_gold,
                           input result_t gold);
    result_t pred;
    if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= sn;
    do @(posedge clk); while (!s_tready);
    pred = predict_lis(v, sn);
    lis_expect_q.insert(lis_expect_q.size(), has_gold ? gold : pred);
    items_in++;
    if (items_in >= QUIET_AT) quiet = 1'b1;
  endtask

  // One random run; all but noise runs open with start_new
  task automatic run_burst();
    burst_kind_t kind;
    int     len;
    value_t cur;
    bit     sn;
    kind    = burst_kind_t'($urandom_range(0, 4));
    len     = (kind == SEQ_RISING) ? $urandom_range(20, 150) : $urandom_range(1, 40);
    gap_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 10 : 40);
    cur     = $urandom;
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_SCATTER: cur = $urandom;
        SEQ_NARROW:  cur = value_t'($urandom_range(0, 15)) - 32'sd8;
        SEQ_RISING:  cur = cur + value_t'($urandom_range(0, 60)) - 32'sd12;
        SEQ_FALLING: cur = cur - value_t'($urandom_range(0, 50));
        default:     cur = $urandom;
      endcase
      // sprinkle range extremes
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(3))
          0:       cur = V_MIN;
          1:       cur = V_MAX;
          2:       cur = 32'sd0;
          default: cur = -32'sd1;
        endcase
      end
      sn = (kind == SEQ_NOISE) ? ($urandom_range(2) == 0) : (i == 0);
      send_item(cur, sn, 1'b0, '0);
    end
  endtask

  // Stimulus: reset, directed table, random runs, full-table run, quiet tail
  initial begin
    value_t fv;
    dir_rows = '{
      '{32'sd0,        1'b0, 1'b1, result_t'{11'd1, 10'd0, 1'b1, 1'b0}},  // empty table
      '{V_MAX,         1'b0, 1'b1, result_t'{11'd2, 10'd1, 1'b1, 1'b0}},
      '{V_MIN,         1'b0, 1'b1, result_t'{11'd2, 10'd0, 1'b0, 1'b0}},
      '{V_MAX,         1'b0, 1'b1, result_t'{11'd2, 10'd1, 1'b0, 1'b0}},  // equal to tail
      '{V_MIN,         1'b0, 1'b1, result_t'{11'd2, 10'd0, 1'b0, 1'b0}},
      '{-32'sd1,       1'b1, 1'b1, result_t'{11'd1, 10'd0, 1'b1, 1'b0}},  // new run
      '{32'sd5,        1'b0, 1'b0, result_t'('0)},
      '{32'sd5,        1'b0, 1'b0, result_t'('0)},
      '{32'sd3,        1'b0, 1'b0, result_t'('0)},
      '{32'sd100,      1'b0, 1'b0, result_t'('0)},
      '{32'sd4,        1'b0, 1'b0, result_t'('0)},
      '{-32'sd2,       1'b0, 1'b0, result_t'('0)},
      '{V_MAX,         1'b0, 1'b1, result_t'{11'd4, 10'd3, 1'b1, 1'b0}},
      '{32'sd0,        1'b0, 1'b0, result_t'('0)},
      '{V_MIN,         1'b1, 1'b1, result_t'{11'd1, 10'd0, 1'b1, 1'b0}},
      '{V_MIN,         1'b0, 1'b1, result_t'{11'd1, 10'd0, 1'b0, 1'b0}},
      '{V_MIN + 32'sd1, 1'b0, 1'b1, result_t'{11'd2, 10'd1, 1'b1, 1'b0}},
      '{32'sh5A5A_5A5A, 1'b0, 1'b0, result_t'('0)},
      '{32'shA5A5_A5A5, 1'b1, 1'b0, result_t'('0)},
      '{-32'sd1,       1'b0, 1'b0, result_t'('0)}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 30;
    for (int i = 0; i < DIR_N; i++)
      send_item(dir_rows[i].v, dir_rows[i].sn, dir_rows[i].has_gold, dir_rows[i].gold);

    while (items_in < 450) run_burst();

    // Fill the whole table, then overflow, equal-to-last and deep replaces
    gap_pct = 10;
    fv = V_MIN + value_t'($urandom_range(0, 1000));
    send_item(fv, 1'b1, 1'b0, '0);
    for (int k = 1; k < TB_MAX_LEN; k++) begin
      fv = fv + value_t'($urandom_range(1, 4000000));
      send_item(fv, 1'b0, 1'b0, '0);
    end
    send_item(V_MAX, 1'b0, 1'b0, '0);
    send_item(fv, 1'b0, 1'b0, '0);
    send_item(fv + 32'sd1, 1'b0, 1'b0, '0);
    repeat (12) send_item($urandom, 1'b0, 1'b0, '0);

    while (items_in < ITEM_TARGET) run_burst();
    s_tvalid <= 1'b0;

    while (lis_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold-off to back the block up
  initial begin
    int stall_left;
    int stall_pct;
    int cyc;
    bit held;
    stall_left = 0;
    stall_pct  = 10;
    cyc        = 0;
    held       = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) stall_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 5 : 25);
      if (!held && items_in >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.lis_length   = m_tdata[LEN_OUT_W-1:0];
      got.slot_written = m_tdata[LEN_OUT_W +: SLOT_W];
      got.appended     = m_tuser[0];
      got.overflow     = m_tuser[1];
      if (lis_expect_q.size() == 0) begin
        report_mismatch("unexpected beat, lis_length", got.lis_length, 0);
      end else begin
        want = lis_expect_q.pop_front();
        if (got.lis_length !== want.lis_length)
          report_mismatch("lis_length", got.lis_length, want.lis_length);
        if (got.slot_written !== want.slot_written)
          report_mismatch("slot_written", got.slot_written, want.slot_written);
        if (got.appended !== want.appended)
          report_mismatch("appended", got.appended, want.appended);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
      end
    end
  end

  // Watchdog: cycles without any beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $time, idle_cyc);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
